[design/assert_macros.svh]
// Assertion macros shared by the canvas downsampler RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

[design/sscbd_pkg.sv]
// Shared types and constants of the supersampled canvas downsampler.
// No dependencies.
package sscbd_pkg;

  localparam int NUM_CH  = 4;
  localparam int CHAN_W  = 8;
  localparam int SCALE_W = 3;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int CH_WHITE = 3;

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_READ   = 2'd1,
    REQ_SAMPLE = 2'd2
  } req_t;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef chan_t [NUM_CH-1:0] pix_t;

  // word index of the scale register
  localparam logic [CFG_AW-3:0] CFG_SCALE_IDX = '0;
  localparam logic [SCALE_W-1:0] SCALE_RST    = 3'd1;

endpackage

[design/sscbd_if.sv]
// Request and result channel interfaces of the canvas downsampler.
// Depends on sscbd_pkg.
interface sscbd_req_if;
  import sscbd_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [6:0]        pos_x;
  logic [5:0]        pos_y;
  logic [CHAN_W-1:0] in_red;
  logic [CHAN_W-1:0] in_green;
  logic [CHAN_W-1:0] in_blue;
  logic [CHAN_W-1:0] in_white;

  modport source (
    output valid, req_type, pos_x, pos_y, in_red, in_green, in_blue, in_white,
    input  ready
  );
  modport sink (
    input  valid, req_type, pos_x, pos_y, in_red, in_green, in_blue, in_white,
    output ready
  );
endinterface

interface sscbd_res_if;
  import sscbd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  logic [CHAN_W-1:0] out_white;
  logic              range_error;

  modport source (
    output valid, out_red, out_green, out_blue, out_white, range_error,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_white, range_error,
    output ready
  );
endinterface

[design/sscbd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sscbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 3200
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/sscbd_cfg.sv]
// APB-style configuration register block: holds the supersampling scale.
// Depends on sscbd_pkg.
module sscbd_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sscbd_pkg::CFG_AW-1:0]        paddr,
  input  logic [sscbd_pkg::CFG_DW-1:0]        pwdata,
  output logic [sscbd_pkg::CFG_DW-1:0]        prdata,
  output logic                                pready,
  output logic [sscbd_pkg::SCALE_W-1:0]       scale
);
  import sscbd_pkg::*;

  logic [SCALE_W-1:0] scale_r;
  logic               hit;

  assign hit    = (paddr[CFG_AW-1:2] == CFG_SCALE_IDX);
  assign pready = 1'b1;
  assign scale  = scale_r;
  assign prdata = hit ? CFG_DW'(scale_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RST;
    end else if (psel && penable && pwrite && hit) begin
      scale_r <= pwdata[SCALE_W-1:0];
    end
  end

endmodule

[design/sscbd_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle on all channels.
// Depends on sscbd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sscbd_div #(
  parameter int SUM_W = 12,
  parameter int DIV_W = 5
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        start,
  input  logic [sscbd_pkg::NUM_CH-1:0][SUM_W-1:0]     dividend,
  input  logic [DIV_W-1:0]                            divisor,
  output logic                                        done,
  output logic [sscbd_pkg::NUM_CH-1:0][SUM_W-1:0]     quot
);
  import sscbd_pkg::*;

  localparam int CNT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  logic                              busy_r;
  logic                              done_r;
  logic [CNT_W-1:0]                  cnt_r;
  logic [NUM_CH-1:0][DIV_W-1:0]      rem_r;
  logic [NUM_CH-1:0][SUM_W-1:0]      quo_r;
  logic [NUM_CH-1:0][DIV_W:0]        shifted;
  logic [NUM_CH-1:0][DIV_W:0]        diff;
  logic [NUM_CH-1:0]                 ge;
  logic [NUM_CH-1:0][DIV_W-1:0]      rem_nxt;
  logic [NUM_CH-1:0][SUM_W-1:0]      quo_nxt;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      shifted[c] = {rem_r[c], quo_r[c][SUM_W-1]};
      diff[c]    = shifted[c] - {1'b0, divisor};
      ge[c]      = (shifted[c] >= {1'b0, divisor});
      rem_nxt[c] = ge[c] ? diff[c][DIV_W-1:0] : shifted[c][DIV_W-1:0];
      quo_nxt[c] = {quo_r[c][SUM_W-2:0], ge[c]};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(SUM_W - 1);
        rem_r  <= '0;
        quo_r  <= dividend;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  `ASSERT_CLK(a_div_start_idle, start |-> !busy_r, "divider restarted while busy")
  `ASSERT_CLK(a_div_zero_divisor, busy_r |-> (divisor != '0), "divisor is zero")

endmodule

[design/supersampled_canvas_box_downsample_unit.sv]
// Supersampled RGBW canvas with box-filter downsampling to LED resolution.
// Depends on sscbd_pkg, sscbd_if, sscbd_ram, sscbd_cfg, sscbd_div, assert_macros.svh.
//
// After reset the canvas RAM is swept to zero, one pixel a cycle, over all
// MAX_SCALE*MAX_SCALE*MATRIX_WIDTH*MATRIX_HEIGHT pixels (3200 with the default
// parameters); in_ch.ready stays low meanwhile, configuration writes are taken.
// One request is worked on at a time. A write steps through S_PREP, S_BASE,
// S_WRITE and S_DONE, a read through S_PREP, S_BASE, S_READ, S_READW and S_DONE,
// and an out-of-range request goes from S_PREP straight to S_DONE. A sample request
// reads its scale*scale canvas pixels through the single RAM read port, one a
// cycle, then divides the four channel sums by scale*scale in a bit-serial
// divider, one quotient bit a cycle; SUM_W is 12 bits with MAX_SCALE 4. Results
// sit in an output register, so a new request is taken while one waits.
`include "assert_macros.svh"

module supersampled_canvas_box_downsample_unit #(
  parameter int MATRIX_WIDTH  = 20,
  parameter int MATRIX_HEIGHT = 10,
  parameter int MAX_SCALE     = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  sscbd_req_if.sink                       in_ch,
  sscbd_res_if.source                     out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sscbd_pkg::CFG_AW-1:0]    paddr,
  input  logic [sscbd_pkg::CFG_DW-1:0]    pwdata,
  output logic [sscbd_pkg::CFG_DW-1:0]    prdata,
  output logic                            pready
);
  import sscbd_pkg::*;

  localparam int DEPTH = MAX_SCALE * MAX_SCALE * MATRIX_WIDTH * MATRIX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SCL_W = $clog2(MAX_SCALE + 1);
  localparam int CW_W  = $clog2(MAX_SCALE * MATRIX_WIDTH + 1);
  localparam int CH_W  = $clog2(MAX_SCALE * MATRIX_HEIGHT + 1);
  localparam int DIV_W = $clog2(MAX_SCALE * MAX_SCALE + 1);
  localparam int SUM_W = $clog2(MAX_SCALE * MAX_SCALE * (2 ** CHAN_W - 1) + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PREP, S_BASE, S_WRITE, S_READ, S_READW,
    S_SUM, S_SUMW, S_DIVGO, S_DIV, S_DONE
  } state_t;

  state_t                          state_r, state_nxt;
  logic [AW-1:0]                   clr_r;
  logic [1:0]                      req_r;
  logic [6:0]                      px_r;
  logic [5:0]                      py_r;
  pix_t                            wpix_r;
  logic [SCL_W-1:0]                s_r;
  logic [CW_W-1:0]                 cw_r;
  logic [CW_W-1:0]                 col0_r;
  logic [CH_W-1:0]                 row0_r;
  logic [DIV_W-1:0]                div_r;
  logic                            err_r;
  logic [AW-1:0]                   addr_r;
  logic [AW-1:0]                   row_base_r;
  logic [SCL_W-1:0]                i_r;
  logic [SCL_W-1:0]                j_r;
  logic                            pend_r;
  logic [NUM_CH-1:0][SUM_W-1:0]    acc_r;
  pix_t                            pix_r;
  pix_t                            out_pix_r;
  logic                            out_err_r;
  logic                            out_valid_r;

  logic [SCALE_W-1:0]              scale;
  logic [SCL_W-1:0]                s_eff;
  logic [CW_W-1:0]                 cw_c;
  logic [CH_W-1:0]                 ch_c;
  logic                            prep_err;
  logic [AW-1:0]                   base_c;
  logic                            in_fire;
  logic                            out_load;
  logic                            sum_last;
  logic                            row_last;
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  pix_t                            ram_wdata;
  pix_t                            ram_rdata;
  logic                            div_done;
  logic [NUM_CH-1:0][SUM_W-1:0]    quot;
  logic                            we_ok;
  logic                            quot_ok;

  sscbd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .scale   (scale)
  );

  sscbd_ram #(
    .WIDTH (NUM_CH * CHAN_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  sscbd_div #(
    .SUM_W (SUM_W),
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_DIVGO),
    .dividend (acc_r),
    .divisor  (div_r),
    .done     (div_done),
    .quot     (quot)
  );

  // scale 0 acts as 1, anything above MAX_SCALE as MAX_SCALE
  always_comb begin
    if (scale == '0) begin
      s_eff = SCL_W'(1);
    end else if (4'(scale) > 4'(MAX_SCALE)) begin
      s_eff = SCL_W'(MAX_SCALE);
    end else begin
      s_eff = SCL_W'(scale);
    end
  end

  assign cw_c = CW_W'(s_eff * MATRIX_WIDTH);
  assign ch_c = CH_W'(s_eff * MATRIX_HEIGHT);

  always_comb begin
    if (req_r == REQ_SAMPLE) begin
      prep_err = (16'(px_r) >= 16'(MATRIX_WIDTH)) || (16'(py_r) >= 16'(MATRIX_HEIGHT));
    end else begin
      prep_err = (16'(px_r) >= 16'(cw_c)) || (16'(py_r) >= 16'(ch_c));
    end
  end

  assign base_c   = AW'(col0_r) + AW'(AW'(row0_r) * AW'(cw_r));
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign row_last = (i_r == SCL_W'(s_r - 1'b1));
  assign sum_last = row_last && (j_r == SCL_W'(s_r - 1'b1));

  assign ram_we    = (state_r == S_CLEAR) || (state_r == S_WRITE);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_r : addr_r;
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : wpix_r;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_red     = out_pix_r[CH_RED];
  assign out_ch.out_green   = out_pix_r[CH_GREEN];
  assign out_ch.out_blue    = out_pix_r[CH_BLUE];
  assign out_ch.out_white   = out_pix_r[CH_WHITE];
  assign out_ch.range_error = out_err_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire && (in_ch.req_type inside {REQ_WRITE, REQ_READ, REQ_SAMPLE})) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP:  state_nxt = prep_err ? S_DONE : S_BASE;
      S_BASE: begin
        case (req_r)
          REQ_WRITE: state_nxt = S_WRITE;
          REQ_READ:  state_nxt = S_READ;
          default:   state_nxt = S_SUM;
        endcase
      end
      S_WRITE: state_nxt = S_DONE;
      S_READ:  state_nxt = S_READW;
      S_READW: state_nxt = S_DONE;
      S_SUM: begin
        if (sum_last) state_nxt = S_SUMW;
      end
      S_SUMW:  state_nxt = S_DIVGO;
      S_DIVGO: state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= (state_r == S_SUM);

      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end

      if (in_fire) begin
        req_r  <= in_ch.req_type;
        px_r   <= in_ch.pos_x;
        py_r   <= in_ch.pos_y;
        wpix_r <= {in_ch.in_white, in_ch.in_blue, in_ch.in_green, in_ch.in_red};
      end

      if (state_r == S_PREP) begin
        s_r    <= s_eff;
        cw_r   <= cw_c;
        div_r  <= DIV_W'(DIV_W'(s_eff) * DIV_W'(s_eff));
        err_r  <= prep_err;
        pix_r  <= '0;
        col0_r <= (req_r == REQ_SAMPLE) ? CW_W'(CW_W'(px_r) * CW_W'(s_eff)) : CW_W'(px_r);
        row0_r <= (req_r == REQ_SAMPLE) ? CH_W'(CH_W'(py_r) * CH_W'(s_eff)) : CH_W'(py_r);
      end

      if (state_r == S_BASE) begin
        addr_r     <= base_c;
        row_base_r <= base_c;
        i_r        <= '0;
        j_r        <= '0;
        acc_r      <= '0;
      end

      if ((state_r == S_SUM && pend_r) || state_r == S_SUMW) begin
        for (int c = 0; c < NUM_CH; c++) begin
          acc_r[c] <= acc_r[c] + SUM_W'(ram_rdata[c]);
        end
      end

      // walk the block row by row through the canvas
      if (state_r == S_SUM) begin
        if (row_last) begin
          i_r        <= '0;
          j_r        <= j_r + 1'b1;
          row_base_r <= row_base_r + AW'(cw_r);
          addr_r     <= row_base_r + AW'(cw_r);
        end else begin
          i_r    <= i_r + 1'b1;
          addr_r <= addr_r + 1'b1;
        end
      end

      if (state_r == S_READW) begin
        pix_r <= ram_rdata;
      end

      if (state_r == S_DIV && div_done) begin
        for (int c = 0; c < NUM_CH; c++) begin
          pix_r[c] <= quot[c][CHAN_W-1:0];
        end
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
        out_pix_r   <= pix_r;
        out_err_r   <= err_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign we_ok   = (state_r == S_CLEAR) || ((state_r == S_WRITE) && !err_r);
  assign quot_ok = (quot[CH_RED] <= SUM_W'(255)) && (quot[CH_GREEN] <= SUM_W'(255)) &&
                   (quot[CH_BLUE] <= SUM_W'(255)) && (quot[CH_WHITE] <= SUM_W'(255));

  `ASSERT_CLK(a_ram_we_state, ram_we |-> we_ok, "canvas written outside clear or valid write")
  `ASSERT_CLK(a_ram_waddr_range, ram_we |-> (ram_waddr <= AW'(DEPTH - 1)), "write beyond store")
  `ASSERT_CLK(a_sum_idx_range, (state_r == S_SUM) |-> (i_r < s_r && j_r < s_r), "bad block index")
  `ASSERT_CLK(a_div_done_state, div_done |-> (state_r == S_DIV), "divider done outside S_DIV")
  `ASSERT_CLK(a_quot_fits, div_done |-> quot_ok, "block average exceeds channel range")

endmodule

[tb/sv/tb_supersampled_canvas_box_downsample_unit.sv]
// Self-checking testbench for the supersampled canvas downsampler: a directed table, then
// random write/read/sample beats at several scales, checked against an internal canvas model.
// Depends on sscbd_pkg, sscbd_if and supersampled_canvas_box_downsample_unit.
module tb_supersampled_canvas_box_downsample_unit;
  import sscbd_pkg::*;

  localparam int MATRIX_W      = 20;
  localparam int MATRIX_H      = 10;
  localparam int SCALE_MAX     = 4;
  localparam int CANVAS_DEPTH  = SCALE_MAX * SCALE_MAX * MATRIX_W * MATRIX_H;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int BEATS_PER_SCALE = 100;
  localparam int NUM_DIRECTED  = 20;
  localparam int NUM_SCALES    = 7;
  localparam int REPORT_MAX    = 10;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [SCALE_W-1:0] SCALE_PLAN [NUM_SCALES] =
    '{3'd4, 3'd2, 3'd0, 3'd7, 3'd3, 3'd5, 3'd1};

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] x;
    logic [5:0] y;
    pix_t       colour;
  } canvas_req_t;

  typedef struct packed {
    pix_t colour;
    logic err;
  } pixel_res_t;

  typedef struct packed {
    canvas_req_t rq;
    logic        fixed;
    pixel_res_t  res;
  } directed_row_t;

  // scale 1 throughout; colours packed white..red, msb first
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{'{REQ_READ,    7'd0,   6'd0,  32'h0},        1'b1, '{32'h0,        1'b0}},
    '{'{REQ_SAMPLE,  7'd0,   6'd0,  32'h0},        1'b1, '{32'h0,        1'b0}},
    '{'{REQ_WRITE,   7'd0,   6'd0,  32'hffffffff}, 1'b1, '{32'h0,        1'b0}},
    '{'{REQ_WRITE,   7'd19,  6'd9,  32'hc33c5aa5}, 1'b1, '{32'h0,        1'b0}},
    '{'{REQ_READ,    7'd0,   6'd0,  32'h0},        1'b1, '{32'hffffffff, 1'b0}},
    '{'{REQ_READ,    7'd19,  6'd9,  32'h0},        1'b1, '{32'hc33c5aa5, 1'b0}},
    '{'{REQ_WRITE,   7'd20,  6'd0,  32'h12345678}, 1'b1, '{32'h0,        1'b1}},
    '{'{REQ_WRITE,   7'd0,   6'd10, 32'h87654321}, 1'b1, '{32'h0,        1'b1}},
    '{'{REQ_READ,    7'd127, 6'd63, 32'h0},        1'b1, '{32'h0,        1'b1}},
    '{'{REQ_SAMPLE,  7'd20,  6'd0,  32'h0},        1'b1, '{32'h0,        1'b1}},
    '{'{REQ_SAMPLE,  7'd0,   6'd10, 32'h0},        1'b1, '{32'h0,        1'b1}},
    '{'{REQ_SAMPLE,  7'd127, 6'd63, 32'h0},        1'b1, '{32'h0,        1'b1}},
    '{'{REQ_UNUSED,  7'd127, 6'd63, 32'hffffffff}, 1'b0, '{32'h0,        1'b0}},
    '{'{REQ_SAMPLE,  7'd19,  6'd9,  32'h0},        1'b1, '{32'hc33c5aa5, 1'b0}},
    '{'{REQ_WRITE,   7'd1,   6'd0,  32'hfe017f80}, 1'b0, '{32'h0,        1'b0}},
    '{'{REQ_READ,    7'd1,   6'd0,  32'h0},        1'b0, '{32'h0,        1'b0}},
    '{'{REQ_SAMPLE,  7'd1,   6'd0,  32'h0},        1'b0, '{32'h0,        1'b0}},
    '{'{REQ_WRITE,   7'd64,  6'd32, 32'h55aa55aa}, 1'b1, '{32'h0,        1'b1}},
    '{'{REQ_READ,    7'd19,  6'd0,  32'h0},        1'b0, '{32'h0,        1'b0}},
    '{'{REQ_WRITE,   7'd0,   6'd9,  32'h0},        1'b0, '{32'h0,        1'b0}}
  };

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  sscbd_req_if in_ch ();
  sscbd_res_if out_ch ();

  supersampled_canvas_box_downsample_unit #(
    .MATRIX_WIDTH (MATRIX_W),
    .MATRIX_HEIGHT(MATRIX_H),
    .MAX_SCALE    (SCALE_MAX)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  pix_t             canvas_mem [CANVAS_DEPTH];
  logic [SCALE_W-1:0] scale_reg;
  pixel_res_t       pending_pixels [$];
  int unsigned      mismatch_count;
  int unsigned      cycle_count;
  int unsigned      src_idle_pct;
  int unsigned      sink_stall_pct;
  logic             drv_fixed;
  pixel_res_t       drv_fixed_res;

  always #2 clk = ~clk;

  function automatic int unsigned eff_scale();
    if (scale_reg == 0) return 1;
    if (scale_reg > SCALE_MAX) return SCALE_MAX;
    return scale_reg;
  endfunction

  // Applies one request to the canvas copy and returns the result it should give.
  function automatic pixel_res_t canvas_access(input canvas_req_t rq);
    int unsigned s;
    int unsigned cw;
    int unsigned ch;
    int unsigned addr;
    int unsigned sum [NUM_CH];
    int unsigned i;
    int unsigned j;
    int unsigned c;
    pixel_res_t r;
    s  = eff_scale();
    cw = s * MATRIX_W;
    ch = s * MATRIX_H;
    r  = '0;
    case (rq.kind)
      REQ_WRITE, REQ_READ: begin
        if (rq.x >= cw || rq.y >= ch) begin
          r.err = 1'b1;
        end else begin
          addr = rq.x + rq.y * cw;
          if (rq.kind == REQ_WRITE) canvas_mem[addr] = rq.colour;
          else r.colour = canvas_mem[addr];
        end
      end
      default: begin
        if (rq.x >= MATRIX_W || rq.y >= MATRIX_H) begin
          r.err = 1'b1;
        end else begin
          for (c = 0; c < NUM_CH; c++) sum[c] = 0;
          for (i = 0; i < s; i++) begin
            for (j = 0; j < s; j++) begin
              addr = (rq.x * s + i) + (rq.y * s + j) * cw;
              for (c = 0; c < NUM_CH; c++) sum[c] += canvas_mem[addr][c];
            end
          end
          for (c = 0; c < NUM_CH; c++) r.colour[c] = chan_t'(sum[c] / (s * s));
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : beat_monitor
    pixel_res_t want;
    pixel_res_t got;
    canvas_req_t rq;
    logic bad;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.colour[CH_RED]   = out_ch.out_red;
        got.colour[CH_GREEN] = out_ch.out_green;
        got.colour[CH_BLUE]  = out_ch.out_blue;
        got.colour[CH_WHITE] = out_ch.out_white;
        got.err              = out_ch.range_error;
        if (pending_pixels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("[%0t] unexpected result beat: rgbw %h err %b", $time, got.colour,
                     got.err);
        end else begin
          want = pending_pixels.pop_front();
          bad = 1'b0;
          for (int c = 0; c < NUM_CH; c++)
            if (got.colour[c] !== want.colour[c]) bad = 1'b1;
          if (got.err !== want.err) bad = 1'b1;
          if (bad) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
              $display("[%0t] result mismatch: expected rgbw %h err %b, got rgbw %h err %b",
                       $time, want.colour, want.err, got.colour, got.err);
          end
        end
      end
      if (in_ch.valid && in_ch.ready && in_ch.req_type != REQ_UNUSED) begin
        rq.kind             = in_ch.req_type;
        rq.x                = in_ch.pos_x;
        rq.y                = in_ch.pos_y;
        rq.colour[CH_RED]   = in_ch.in_red;
        rq.colour[CH_GREEN] = in_ch.in_green;
        rq.colour[CH_BLUE]  = in_ch.in_blue;
        rq.colour[CH_WHITE] = in_ch.in_white;
        want = canvas_access(rq);
        if (drv_fixed) want = drv_fixed_res;
        pending_pixels.push_back(want);
      end
    end
  end

  always @(negedge clk)
    out_ch.ready = (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("supersampled_canvas_box_downsample_unit test failed");
      $finish;
    end
  end

  task automatic drive_req(input canvas_req_t rq, input logic fixed, input pixel_res_t res);
    @(negedge clk);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.req_type = rq.kind;
    in_ch.pos_x    = rq.x;
    in_ch.pos_y    = rq.y;
    in_ch.in_red   = rq.colour[CH_RED];
    in_ch.in_green = rq.colour[CH_GREEN];
    in_ch.in_blue  = rq.colour[CH_BLUE];
    in_ch.in_white = rq.colour[CH_WHITE];
    drv_fixed      = fixed;
    drv_fixed_res  = res;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  initial begin
    canvas_req_t rq;
    int unsigned s;
    int unsigned pick;
    int unsigned done;
    logic hot;
    clk            = 1'b0;
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = '0;
    in_ch.pos_x    = '0;
    in_ch.pos_y    = '0;
    in_ch.in_red   = '0;
    in_ch.in_green = '0;
    in_ch.in_blue  = '0;
    in_ch.in_white = '0;
    out_ch.ready   = 1'b0;
    drv_fixed      = 1'b0;
    drv_fixed_res  = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    scale_reg      = SCALE_RST;
    for (int a = 0; a < CANVAS_DEPTH; a++) canvas_mem[a] = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed beats; ready stays low until the canvas clear is over
    for (int k = 0; k < NUM_DIRECTED; k++)
      drive_req(directed_rows[k].rq, directed_rows[k].fixed, directed_rows[k].res);

    for (int k = 0; k < NUM_SCALES; k++) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clk);

      @(negedge clk);
      psel    = 1'b1;
      pwrite  = 1'b1;
      penable = 1'b0;
      paddr   = {CFG_SCALE_IDX, 2'b00};
      pwdata  = CFG_DW'(SCALE_PLAN[k]);
      @(negedge clk);
      penable = 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      scale_reg = SCALE_PLAN[k];
      @(negedge clk);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;

      case (k % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 84; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 84; end
        default: begin src_idle_pct = 16; sink_stall_pct = 16; end
      endcase

      s    = eff_scale();
      done = 0;
      while (done < BEATS_PER_SCALE) begin
        if (k == 2 && done == BEATS_PER_SCALE / 2) begin
          @(negedge clk);
          in_ch.valid = 1'b0;
          drain_results();
        end
        pick      = $urandom_range(99);
        hot       = ($urandom_range(9) < 6);
        rq.colour = pix_t'($urandom);
        if (pick < 60) begin
          rq.kind = (pick < 40) ? REQ_WRITE : REQ_READ;
          rq.x = 7'(hot ? $urandom_range(4 * s - 1) : $urandom_range(MATRIX_W * s - 1));
          rq.y = 6'(hot ? $urandom_range(3 * s - 1) : $urandom_range(MATRIX_H * s - 1));
        end else if (pick < 88) begin
          rq.kind = REQ_SAMPLE;
          rq.x = 7'(hot ? $urandom_range(3) : $urandom_range(MATRIX_W - 1));
          rq.y = 6'(hot ? $urandom_range(2) : $urandom_range(MATRIX_H - 1));
        end else begin
          // noise over the whole field range; some of it lands out of range
          rq.kind = (pick < 96) ? 2'($urandom_range(2)) : REQ_UNUSED;
          rq.x    = 7'($urandom_range(127));
          rq.y    = 6'($urandom_range(63));
        end
        drive_req(rq, 1'b0, '0);
        if (rq.kind != REQ_UNUSED) done++;
      end
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_pixels.size() == 0)
      $display("supersampled_canvas_box_downsample_unit test passed");
    else
      $display("supersampled_canvas_box_downsample_unit test failed");
    $finish;
  end

endmodule
